### src/sirs_pkg.sv
// Package for the signed integer to radix symbols converter.
// Holds widths, register indexes and character codes; no dependencies.
package sirs_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_BITS    = 8;
  localparam int CNT_BITS    = 5;
  localparam int DIGIT_BITS  = 4;
  localparam int IDX_BITS    = $clog2(VALUE_BITS);
  localparam int PROD_BITS   = VALUE_BITS + CNT_BITS;
  localparam int TRIAL_BITS  = VALUE_BITS + DIGIT_BITS;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 64;

  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

  localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_BITS-1:0] CHAR_NUL   = 8'h00;

endpackage

### src/signed_integer_to_radix_symbols_top.sv
// Top level of the signed integer to radix symbols converter.
// Sequencer with one shared multiply/compare-subtract unit; uses sirs_pkg.
//
//   channel | ports                                      | role
//   --------+--------------------------------------------+------------------------------
//   in      | in_valid, in_ready, in_value               | signed value, one per beat
//   out     | out_valid, out_ready, out_symbol, out_last | one character per beat
//   cfg     | psel, penable, pwrite, paddr, pwdata...    | alphabet and radix registers
//
// For an item in radix r the sequencer first builds the powers of r with the
// multiplier; then each digit costs a power load, nb compare-subtract steps and an
// emit, nb being the bit width of r-1 (1..4).
// Radix 2 on the most negative value is the longest case.
// rst_n is synchronous and clears control state and the registers.
// in_ready is high only while idle; a held output beat stalls the sequencer.
module signed_integer_to_radix_symbols_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirs_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sirs_pkg::SYM_BITS-1:0]        out_symbol,
  output logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sirs_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [sirs_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sirs_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import sirs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_POW   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIG   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_WAIT  = 3'd7;

  logic [DATA_BITS-1:0]  sym_low_r;
  logic [DATA_BITS-1:0]  sym_high_r;
  logic [CNT_BITS-1:0]   sym_cnt_r;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [VALUE_BITS-1:0] pow_r, pow_nxt;
  logic [VALUE_BITS-1:0] dv_r, dv_nxt;
  logic [IDX_BITS-1:0]   k_r, k_nxt;
  logic [1:0]            b_r, b_nxt;
  logic [DIGIT_BITS-1:0] digit_r, digit_nxt;
  logic                  neg_r, neg_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SYM_BITS-1:0]   out_symbol_r, out_symbol_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] pow_mem [VALUE_BITS];
  logic [VALUE_BITS-1:0] pw_rd_r;
  logic                  pw_we;

  logic [SYM_BITS-1:0]   sym [MAX_SYMBOLS];
  logic                  alpha_ok;
  logic [PROD_BITS-1:0]  prod;
  logic [TRIAL_BITS-1:0] trial;
  logic [TRIAL_BITS-1:0] mag_ext;
  logic [1:0]            b_top;
  logic                  slot_free;
  logic                  cfg_we;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r  <= '0;
      sym_high_r <= '0;
      sym_cnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:3])
        REG_SYMBOLS_LOW:  sym_low_r  <= pwdata;
        REG_SYMBOLS_HIGH: sym_high_r <= pwdata;
        REG_SYMBOL_COUNT: sym_cnt_r  <= pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SYMBOLS_LOW:  prdata = sym_low_r;
      REG_SYMBOLS_HIGH: prdata = sym_high_r;
      REG_SYMBOL_COUNT: prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, sym_cnt_r};
      default:          prdata = '0;
    endcase
  end

  // alphabet check
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym[i]   = sym_low_r[8*i +: 8];
      sym[i+8] = sym_high_r[8*i +: 8];
    end
  end

  always_comb begin
    alpha_ok = (sym_cnt_r >= CNT_BITS'(2)) && (sym_cnt_r <= CNT_BITS'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (CNT_BITS'(i) < sym_cnt_r) begin
        if (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS)
          alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if (CNT_BITS'(j) < sym_cnt_r && sym[i] == sym[j])
          alpha_ok = 1'b0;
      end
    end
  end

  // power table
  always_ff @(posedge clk) begin
    if (pw_we) pow_mem[k_r] <= pow_r;
    pw_rd_r <= pow_mem[k_r];
  end

  // shared arithmetic
  assign prod    = PROD_BITS'(pow_r) * PROD_BITS'(sym_cnt_r);
  assign trial   = {{DIGIT_BITS{1'b0}}, dv_r} << b_r;
  assign mag_ext = {{DIGIT_BITS{1'b0}}, mag_r};

  always_comb begin
    if      (sym_cnt_r > CNT_BITS'(8)) b_top = 2'd3;
    else if (sym_cnt_r > CNT_BITS'(4)) b_top = 2'd2;
    else if (sym_cnt_r > CNT_BITS'(2)) b_top = 2'd1;
    else                               b_top = 2'd0;
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    mag_nxt        = mag_r;
    pow_nxt        = pow_r;
    dv_nxt         = dv_r;
    k_nxt          = k_r;
    b_nxt          = b_r;
    digit_nxt      = digit_r;
    neg_nxt        = neg_r;
    pw_we          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!alpha_ok) begin
          state_nxt = S_IDLE;
        end else begin
          neg_nxt   = val_r[VALUE_BITS-1];
          mag_nxt   = val_r[VALUE_BITS-1] ? (~val_r + VALUE_BITS'(1)) : val_r;
          pow_nxt   = VALUE_BITS'(1);
          k_nxt     = '0;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        pw_we = 1'b1;
        if (prod <= PROD_BITS'(mag_r)) begin
          pow_nxt = prod[VALUE_BITS-1:0];
          k_nxt   = k_r + IDX_BITS'(1);
        end else begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!neg_r) begin
          state_nxt = S_LOAD;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = CHAR_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = S_LOAD;
        end
      end
      S_LOAD: begin
        dv_nxt    = pw_rd_r;
        b_nxt     = b_top;
        digit_nxt = '0;
        state_nxt = S_DIG;
      end
      S_DIG: begin
        if (mag_ext >= trial) begin
          mag_nxt        = mag_r - trial[VALUE_BITS-1:0];
          digit_nxt[b_r] = 1'b1;
        end
        if (b_r == 2'd0) state_nxt = S_EMIT;
        else             b_nxt     = b_r - 2'd1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = sym[digit_r];
          out_last_nxt   = (k_r == '0);
          if (k_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r - IDX_BITS'(1);
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      neg_r       <= 1'b0;
      mag_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    pow_r        <= pow_nxt;
    dv_r         <= dv_nxt;
    b_r          <= b_nxt;
    digit_r      <= digit_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule
